>>> rtl/crf_pkg.sv
// Shared types and constants of the coverage run framer.
package crf_pkg;

   localparam int CRF_QUEUE_DEPTH = 4;

   localparam int CHROM_W = 16;
   localparam int POS_W   = 31;
   localparam int DEPTH_W = 31;
   localparam int GAP_W   = 6;
   localparam int LIMIT_W = 6;

   localparam logic [POS_W-1:0]   RANGE_BEGIN_RESET = '0;
   localparam logic [POS_W-1:0]   RANGE_END_RESET   = 31'h7FFF_FFFF;
   localparam logic [LIMIT_W-1:0] ZERO_LIMIT_RESET  = 6'd10;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX         = 6'd62;
   localparam logic [GAP_W-1:0]   GAP_SAT           = 6'd63;

   typedef enum logic [1:0] {
      CSR_RANGE_BEGIN = 2'd0,
      CSR_RANGE_END   = 2'd1,
      CSR_ZERO_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_ZERO   = 2'd1,
      KIND_DEPTH  = 2'd2
   } kind_type;

   // One classified record, handed from front to back.
   typedef struct packed {
      logic               header;
      logic [CHROM_W-1:0] chrom;
      logic [POS_W-1:0]   start;
      logic [GAP_W-1:0]   zeros;
      logic [DEPTH_W-1:0] depth;
   } cmd_type;

endpackage

>>> rtl/crf_front.sv
// Front part: window filter, gap tracking, block classification, config registers.
module crf_front
   import crf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   output logic         push_valid,
   input  logic         push_ready,
   output cmd_type      push_data
);

   logic [POS_W-1:0]   range_begin_ff, range_begin_in;
   logic [POS_W-1:0]   range_end_ff, range_end_in;
   logic [LIMIT_W-1:0] zero_limit_ff, zero_limit_in;

   logic               seen_ff, seen_in;
   logic [CHROM_W-1:0] last_chrom_ff, last_chrom_in;
   logic [31:0]        last_nz_ff, last_nz_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;

   logic [CHROM_W-1:0] chrom;
   logic [POS_W-1:0]   pos;
   logic [DEPTH_W-1:0] depth;
   logic               in_window;
   logic               nonzero;
   logic               accept;
   logic [31:0]        next_pos;
   logic [32:0]        expect_pos;
   logic [LIMIT_W-1:0] limit;
   logic               new_block;

   assign chrom   = req_tdata[15:0];
   assign pos     = req_tdata[46:16];
   assign depth   = req_tdata[77:47];

   assign in_window = (pos >= range_begin_ff) && (pos < range_end_ff);
   assign nonzero   = (depth != '0);
   assign accept    = req_tvalid && req_tready;

   // All ones stands for minus one, so the increment wraps to position zero.
   assign next_pos   = last_nz_ff + 32'd1;
   assign expect_pos = {1'b0, next_pos} + {27'd0, gap_ff};
   assign limit      = (zero_limit_ff > LIMIT_MAX) ? LIMIT_MAX : zero_limit_ff;

   assign new_block = !seen_ff || (last_chrom_ff != chrom) ||
                      (expect_pos != {2'b00, pos}) || (gap_ff > limit);

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && in_window && nonzero;

   always_comb begin
      push_data.header = new_block;
      push_data.chrom  = chrom;
      push_data.start  = pos + 31'd1;
      push_data.zeros  = new_block ? '0 : gap_ff;
      push_data.depth  = depth;
   end

   always_comb begin
      range_begin_in = range_begin_ff;
      range_end_in   = range_end_ff;
      zero_limit_in  = zero_limit_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RANGE_BEGIN: range_begin_in = csr_wdata;
            CSR_RANGE_END:   range_end_in   = csr_wdata;
            CSR_ZERO_LIMIT:  zero_limit_in  = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      seen_in       = seen_ff;
      last_chrom_in = last_chrom_ff;
      last_nz_in    = last_nz_ff;
      gap_in        = gap_ff;
      if (accept && in_window) begin
         seen_in       = 1'b1;
         last_chrom_in = chrom;
         if (nonzero) begin
            last_nz_in = {1'b0, pos};
            gap_in     = '0;
         end else if (gap_ff != GAP_SAT) begin
            gap_in = gap_ff + GAP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_begin_ff <= RANGE_BEGIN_RESET;
         range_end_ff   <= RANGE_END_RESET;
         zero_limit_ff  <= ZERO_LIMIT_RESET;
         seen_ff        <= 1'b0;
         last_chrom_ff  <= '0;
         last_nz_ff     <= '1;
         gap_ff         <= '0;
      end else begin
         range_begin_ff <= range_begin_in;
         range_end_ff   <= range_end_in;
         zero_limit_ff  <= zero_limit_in;
         seen_ff        <= seen_in;
         last_chrom_ff  <= last_chrom_in;
         last_nz_ff     <= last_nz_in;
         gap_ff         <= gap_in;
      end
   end

endmodule

>>> rtl/crf_queue.sv
// Short command queue between front and back.
module crf_queue
   import crf_pkg::*;
#(
   parameter int DEPTH = CRF_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slots_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push;
   logic            pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Wrap pointers explicitly so any depth works.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/crf_back.sv
// Back part: expands each command into header, zero fill and depth beats.
module crf_back
   import crf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  cmd_type      pop_data,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   logic        active_ff, active_in;
   cmd_type     cmd_ff, cmd_in;
   logic        valid_ff, valid_in;
   logic [47:0] data_ff, data_in;
   kind_type    kind_ff, kind_in;
   logic        last_ff, last_in;

   cmd_type     cur;
   cmd_type     cur_next;
   logic        cur_valid;
   logic        out_free;
   logic        advance;
   logic        finish;
   logic [47:0] beat_data;
   kind_type    beat_kind;

   assign cur       = active_ff ? cmd_ff : pop_data;
   assign cur_valid = active_ff || pop_valid;
   assign out_free  = !valid_ff || rsp_tready;
   assign advance   = cur_valid && out_free;
   assign pop_ready = !active_ff && out_free;

   // Header first, then pending zero fills, then the depth closes the record.
   always_comb begin
      cur_next = cur;
      finish   = 1'b0;
      priority if (cur.header) begin
         beat_kind       = KIND_HEADER;
         beat_data       = {1'b0, cur.start, cur.chrom};
         cur_next.header = 1'b0;
      end else if (cur.zeros != '0) begin
         beat_kind      = KIND_ZERO;
         beat_data      = '0;
         cur_next.zeros = cur.zeros - GAP_W'(1);
      end else begin
         beat_kind = KIND_DEPTH;
         beat_data = {1'b0, cur.depth, 16'd0};
         finish    = 1'b1;
      end
   end

   always_comb begin
      active_in = active_ff;
      cmd_in    = cmd_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      if (advance) begin
         active_in = !finish;
         cmd_in    = cur_next;
         valid_in  = 1'b1;
         data_in   = beat_data;
         kind_in   = beat_kind;
         last_in   = finish;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      cmd_ff  <= cmd_in;
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> rtl/coverage_run_framer_unit.sv
// From acceptance (empty queue), the first beat of a record is registered in a queue slot and
// then in the back end's output register before it shows on rsp.
// Throughput: req takes one record per cycle while the command queue has room; out-of-window
// and zero-depth records need no back-end time. A record with n result beats (1 to 63) holds
// the back end until all are sent, one beat per cycle unless rsp stalls, so the expansion unit
// sets the sustained rate. Reset (synchronous, active high): config returns to defaults,
// tracking state clears, the queue empties and rsp_tvalid drops.
module coverage_run_framer_unit
   import crf_pkg::*;
#(
   parameter int QUEUE_DEPTH = CRF_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   // config write port
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_wdata,
   // record input
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // chrom_id[15:0], position[46:16], depth[77:47], zero pad
   // result output
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // chrom_out[15:0], value[46:16], zero pad
   output logic [1:0]   rsp_tuser,   // kind[1:0]
   output logic         rsp_tlast
);

   // Commands flow front -> queue -> back; each side stalls on its own.
   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_data;

   // Classify each beat: drop out-of-window records, count gaps, decide on a new block.
   crf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Hold classified records until the back end is free.
   crf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Expand each record into its result beats behind an output register.
   crf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/crf_checker.sv
// Port-level assertions for the coverage run framer, bound to the top level.
module crf_checker
   import crf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_last_on_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_DEPTH)))
      else $error("tlast must mark exactly the depth beat");

   a_fill_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ZERO) |-> (rsp_tdata == '0))
      else $error("zero fill beat carries data");

endmodule

bind coverage_run_framer_unit crf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
